@@ hw/rtl/plr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plr_pkg
// shared constants, types and helpers of the arc-length resampler
// ----------------------------------------------------------------------------
package plr_pkg;

  localparam int MAX_EMIT  = 64;
  localparam int FRAC_BITS = 16;

  localparam int CNT_W  = $clog2(MAX_EMIT + 1);
  localparam int STEP_W = 23;
  localparam int ACC_W  = 66;
  localparam int DW     = 33;

  // minimum step of 0.1 m, rounded up
  localparam logic [STEP_W-1:0] STEP_MIN =
    STEP_W'(((64'd1 << FRAC_BITS) + 64'd9) / 64'd10);

  // squared distance above which the end vertex is far from the last point (1 mm)
  localparam logic [ACC_W-1:0] FAR_THR =
    ACC_W'((66'd1 << (2 * FRAC_BITS - 6)) / 66'd15625);

  // serial arithmetic unit operations
  localparam logic [1:0] OP_MAC  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
    logic       load;
  } plr_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } plr_stat_t;

  function automatic logic [DW-1:0] plr_mag(input logic [DW-1:0] d);
    plr_mag = d[DW-1] ? DW'(-d) : d;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/plr_vertex_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plr_vertex_if
// vertex channel: valid, ready and one polyline vertex
// ----------------------------------------------------------------------------
interface plr_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic               path_end;

  modport source (output valid, vertex_x, vertex_y, vertex_z, path_end, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, path_end, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/plr_point_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plr_point_if
// point channel: valid, ready and one resampled point
// ----------------------------------------------------------------------------
interface plr_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               last_of_run;
  logic               truncated;

  modport source (output valid, point_x, point_y, point_z, last_of_run, truncated,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_of_run, truncated,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/polyline_arc_length_resampler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_arc_length_resampler
// resamples a 3-d polyline at a fixed planar arc-length step
// ----------------------------------------------------------------------------
// Vertices arrive one per transfer; the first vertex of a path comes out as it
// is, later segments produce points spaced step_length apart along the x-y
// path with z interpolated, and the path_end vertex is added when more than
// 1 mm from the last point. One vertex is worked on at a time, and the
// multiplies, divides and square roots run one bit per cycle through a single
// shared serial unit (multiply-accumulate, divide, square root). A segment's
// length is the root of the sum of two squares; each emitted point takes, for
// each of the three axes, a multiply and a divide; an end vertex adds a distance
// check of two squares. A finished point waits in the output register so the
// next one is computed meanwhile.
// ----------------------------------------------------------------------------
module polyline_arc_length_resampler
  import plr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [STEP_W-1:0] cfg_wr_data,
  plr_vertex_if.sink             in_vertex,
  plr_point_if.source            out_point
);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIRST   = 4'd1;
  localparam logic [3:0] S_SQ      = 4'd2;
  localparam logic [3:0] S_LOOP    = 4'd3;
  localparam logic [3:0] S_PT      = 4'd4;
  localparam logic [3:0] S_PUSHPT  = 4'd5;
  localparam logic [3:0] S_FAR     = 4'd6;
  localparam logic [3:0] S_PUSHEND = 4'd7;
  localparam logic [3:0] S_FINAL   = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cfg_step_r;
  logic              in_path_r, in_path_nxt;

  // path state
  logic [31:0]       prev_x_r, prev_y_r, prev_z_r, prev_x_nxt, prev_y_nxt, prev_z_nxt;
  logic [33:0]       pend_r, pend_nxt;
  logic [31:0]       emx_r, emy_r, emx_nxt, emy_nxt;

  // current vertex and segment
  logic [31:0]       vx_r, vy_r, vz_r, vx_nxt, vy_nxt, vz_nxt;
  logic              vend_r, vend_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DW-1:0]     dx_r, dy_r, dz_r, dx_nxt, dy_nxt, dz_nxt;
  logic [DW-1:0]     seg_r, seg_nxt;
  logic [34:0]       c_r, c_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              trunc_r, trunc_nxt;
  logic              far_r, far_nxt;
  logic [1:0]        ph_r, ph_nxt;
  logic              wait_r, wait_nxt;
  logic [1:0]        ax_r, ax_nxt;

  // computed point and the held point that still waits for its last flag
  logic [31:0]       ptx_r, pty_r, ptz_r, ptx_nxt, pty_nxt, ptz_nxt;
  logic [31:0]       hx_r, hy_r, hz_r, hx_nxt, hy_nxt, hz_nxt;
  logic              held_v_r, held_v_nxt;

  // output register
  logic              ov_r, ov_nxt;
  logic [31:0]       ox_r, oy_r, oz_r, ox_nxt, oy_nxt, oz_nxt;
  logic              olast_r, olast_nxt, otrunc_r, otrunc_nxt;

  // serial unit
  plr_cmd_t          ar_cmd;
  plr_stat_t         ar_stat;
  logic [DW-1:0]     ar_opa, ar_opb;
  logic [ACC_W-1:0]  ar_init, ar_acc;

  logic              slot_free, accept, push, push_last;
  logic [31:0]       push_x, push_y, push_z;
  logic [CNT_W-1:0]  budget;
  logic [34:0]       lim;
  logic [DW-1:0]     d_sel, ex, ey;
  logic [31:0]       base_sel, pt_val;
  logic [STEP_W-1:0] step_eff;

  plr_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ar_cmd),
    .opa   (ar_opa),
    .opb   (ar_opb),
    .init  (ar_init),
    .stat  (ar_stat),
    .acc   (ar_acc)
  );

  assign in_vertex.ready = (state_r == S_IDLE);
  assign accept          = in_vertex.valid && (state_r == S_IDLE);
  assign slot_free       = !ov_r || out_point.ready;
  assign step_eff        = (cfg_step_r < STEP_MIN) ? STEP_MIN : cfg_step_r;
  // one slot is kept for the end vertex
  assign budget          = vend_r ? CNT_W'(MAX_EMIT - 1) : CNT_W'(MAX_EMIT);

  // distance from the end vertex to the last emitted point
  assign ex = {vx_r[31], vx_r} - {emx_r[31], emx_r};
  assign ey = {vy_r[31], vy_r} - {emy_r[31], emy_r};

  always_comb begin
    unique case (ax_r)
      2'd0:    begin d_sel = dx_r; base_sel = prev_x_r; end
      2'd1:    begin d_sel = dy_r; base_sel = prev_y_r; end
      default: begin d_sel = dz_r; base_sel = prev_z_r; end
    endcase
  end

  // rounded quotient moves from the previous vertex towards this one
  assign pt_val = d_sel[DW-1] ? (base_sel - ar_acc[31:0]) : (base_sel + ar_acc[31:0]);

  // segment needs more points than the budget
  assign lim = {1'b0, pend_r} + (vend_r ? 35'(MAX_EMIT - 1) * 35'(step_r)
                                        : 35'(MAX_EMIT) * 35'(step_r));

  // operation issued to the serial unit
  always_comb begin
    ar_cmd  = '0;
    ar_opa  = '0;
    ar_opb  = '0;
    ar_init = '0;
    unique case (state_r)
      S_SQ: begin
        ar_cmd.start = !wait_r;
        priority if (ph_r == 2'd0) begin
          ar_cmd.op   = OP_MAC;
          ar_cmd.load = 1'b1;
          ar_opa      = plr_mag(dx_r);
          ar_opb      = plr_mag(dx_r);
        end else if (ph_r == 2'd1) begin
          ar_cmd.op = OP_MAC;
          ar_opa    = plr_mag(dy_r);
          ar_opb    = plr_mag(dy_r);
        end else begin
          ar_cmd.op = OP_SQRT;
        end
      end
      S_PT: begin
        ar_cmd.start = !wait_r;
        if (ph_r == 2'd0) begin
          ar_cmd.op   = OP_MAC;
          ar_cmd.load = 1'b1;
          ar_init     = ACC_W'(seg_r >> 1);
          ar_opa      = plr_mag(d_sel);
          ar_opb      = c_r[DW-1:0];
        end else begin
          ar_cmd.op = OP_DIV;
          ar_opb    = seg_r;
        end
      end
      S_FAR: begin
        ar_cmd.start = !wait_r;
        ar_cmd.op    = OP_MAC;
        ar_cmd.load  = (ph_r == 2'd0);
        ar_opa       = (ph_r == 2'd0) ? plr_mag(ex) : plr_mag(ey);
        ar_opb       = ar_opa;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    in_path_nxt = in_path_r;
    prev_x_nxt  = prev_x_r;
    prev_y_nxt  = prev_y_r;
    prev_z_nxt  = prev_z_r;
    pend_nxt    = pend_r;
    emx_nxt     = emx_r;
    emy_nxt     = emy_r;
    vx_nxt      = vx_r;
    vy_nxt      = vy_r;
    vz_nxt      = vz_r;
    vend_nxt    = vend_r;
    step_nxt    = step_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    dz_nxt      = dz_r;
    seg_nxt     = seg_r;
    c_nxt       = c_r;
    cnt_nxt     = cnt_r;
    trunc_nxt   = trunc_r;
    far_nxt     = far_r;
    ph_nxt      = ph_r;
    wait_nxt    = wait_r;
    ax_nxt      = ax_r;
    ptx_nxt     = ptx_r;
    pty_nxt     = pty_r;
    ptz_nxt     = ptz_r;
    hx_nxt      = hx_r;
    hy_nxt      = hy_r;
    hz_nxt      = hz_r;
    held_v_nxt  = held_v_r;
    push        = 1'b0;
    push_last   = 1'b0;
    push_x      = hx_r;
    push_y      = hy_r;
    push_z      = hz_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          vx_nxt    = in_vertex.vertex_x;
          vy_nxt    = in_vertex.vertex_y;
          vz_nxt    = in_vertex.vertex_z;
          vend_nxt  = in_vertex.path_end;
          step_nxt  = step_eff;
          trunc_nxt = 1'b0;
          far_nxt   = 1'b0;
          ph_nxt    = 2'd0;
          wait_nxt  = 1'b0;
          dx_nxt = {in_vertex.vertex_x[31], in_vertex.vertex_x} - {prev_x_r[31], prev_x_r};
          dy_nxt = {in_vertex.vertex_y[31], in_vertex.vertex_y} - {prev_y_r[31], prev_y_r};
          dz_nxt = {in_vertex.vertex_z[31], in_vertex.vertex_z} - {prev_z_r[31], prev_z_r};
          if (!in_path_r) begin
            state_nxt   = S_FIRST;
            in_path_nxt = !in_vertex.path_end;
          end else begin
            if (in_vertex.path_end) in_path_nxt = 1'b0;
            // zero-length segment: no points, distance to go unchanged
            if (in_vertex.vertex_x == prev_x_r && in_vertex.vertex_y == prev_y_r) begin
              state_nxt = in_vertex.path_end ? S_FAR : S_FINAL;
            end else begin
              state_nxt = S_SQ;
            end
          end
        end
      end

      S_FIRST: begin
        if (slot_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          push_x     = vx_r;
          push_y     = vy_r;
          push_z     = vz_r;
          emx_nxt    = vx_r;
          emy_nxt    = vy_r;
          prev_x_nxt = vx_r;
          prev_y_nxt = vy_r;
          prev_z_nxt = vz_r;
          pend_nxt   = 34'(step_r);
          state_nxt  = S_IDLE;
        end
      end

      S_SQ: begin
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (ar_stat.done) begin
          wait_nxt = 1'b0;
          if (ph_r == 2'd2) begin
            seg_nxt   = ar_acc[DW-1:0];
            trunc_nxt = lim <= 35'(ar_acc[DW-1:0]);
            c_nxt     = {1'b0, pend_r};
            cnt_nxt   = '0;
            state_nxt = S_LOOP;
          end else begin
            ph_nxt = ph_r + 2'd1;
          end
        end
      end

      S_LOOP: begin
        if (c_r <= 35'(seg_r) && cnt_r < budget) begin
          ax_nxt    = 2'd0;
          ph_nxt    = 2'd0;
          wait_nxt  = 1'b0;
          state_nxt = S_PT;
        end else begin
          // truncated segments restart a full step away
          pend_nxt  = trunc_r ? 34'(step_r) : 34'(c_r - 35'(seg_r));
          ph_nxt    = 2'd0;
          wait_nxt  = 1'b0;
          state_nxt = vend_r ? S_FAR : S_FINAL;
        end
      end

      S_PT: begin
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (ar_stat.done) begin
          wait_nxt = 1'b0;
          if (ph_r == 2'd0) begin
            ph_nxt = 2'd1;
          end else begin
            ph_nxt = 2'd0;
            unique case (ax_r)
              2'd0:    ptx_nxt = pt_val;
              2'd1:    pty_nxt = pt_val;
              default: ptz_nxt = pt_val;
            endcase
            if (ax_r == 2'd2) state_nxt = S_PUSHPT;
            else              ax_nxt    = ax_r + 2'd1;
          end
        end
      end

      S_PUSHPT: begin
        if (!held_v_r || slot_free) begin
          push       = held_v_r;
          hx_nxt     = ptx_r;
          hy_nxt     = pty_r;
          hz_nxt     = ptz_r;
          held_v_nxt = 1'b1;
          emx_nxt    = ptx_r;
          emy_nxt    = pty_r;
          c_nxt      = c_r + 35'(step_r);
          cnt_nxt    = cnt_r + CNT_W'(1);
          state_nxt  = S_LOOP;
        end
      end

      S_FAR: begin
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (ar_stat.done) begin
          wait_nxt = 1'b0;
          if (ph_r == 2'd0) begin
            ph_nxt = 2'd1;
          end else begin
            far_nxt   = ar_acc > FAR_THR;
            state_nxt = S_PUSHEND;
          end
        end
      end

      S_PUSHEND: begin
        if (!far_r) begin
          state_nxt = S_FINAL;
        end else if (!held_v_r || slot_free) begin
          push       = held_v_r;
          hx_nxt     = vx_r;
          hy_nxt     = vy_r;
          hz_nxt     = vz_r;
          held_v_nxt = 1'b1;
          emx_nxt    = vx_r;
          emy_nxt    = vy_r;
          state_nxt  = S_FINAL;
        end
      end

      S_FINAL: begin
        if (!held_v_r || slot_free) begin
          push       = held_v_r;
          push_last  = 1'b1;
          held_v_nxt = 1'b0;
          prev_x_nxt = vx_r;
          prev_y_nxt = vy_r;
          prev_z_nxt = vz_r;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // output register, refilled in the cycle it is taken
  always_comb begin
    ov_nxt     = ov_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oz_nxt     = oz_r;
    olast_nxt  = olast_r;
    otrunc_nxt = otrunc_r;
    if (push) begin
      ov_nxt     = 1'b1;
      ox_nxt     = push_x;
      oy_nxt     = push_y;
      oz_nxt     = push_z;
      olast_nxt  = push_last;
      otrunc_nxt = trunc_r;
    end else if (out_point.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cfg_step_r <= STEP_W'(65536);
      in_path_r  <= 1'b0;
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      prev_z_r   <= '0;
      pend_r     <= '0;
      emx_r      <= '0;
      emy_r      <= '0;
      held_v_r   <= 1'b0;
      ov_r       <= 1'b0;
      wait_r     <= 1'b0;
      ph_r       <= '0;
      ax_r       <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      if (cfg_wr_en) cfg_step_r <= cfg_wr_data;
      in_path_r  <= in_path_nxt;
      prev_x_r   <= prev_x_nxt;
      prev_y_r   <= prev_y_nxt;
      prev_z_r   <= prev_z_nxt;
      pend_r     <= pend_nxt;
      emx_r      <= emx_nxt;
      emy_r      <= emy_nxt;
      held_v_r   <= held_v_nxt;
      ov_r       <= ov_nxt;
      wait_r     <= wait_nxt;
      ph_r       <= ph_nxt;
      ax_r       <= ax_nxt;
      cnt_r      <= cnt_nxt;
    end
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    vz_r     <= vz_nxt;
    vend_r   <= vend_nxt;
    step_r   <= step_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    dz_r     <= dz_nxt;
    seg_r    <= seg_nxt;
    c_r      <= c_nxt;
    trunc_r  <= trunc_nxt;
    far_r    <= far_nxt;
    ptx_r    <= ptx_nxt;
    pty_r    <= pty_nxt;
    ptz_r    <= ptz_nxt;
    hx_r     <= hx_nxt;
    hy_r     <= hy_nxt;
    hz_r     <= hz_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    oz_r     <= oz_nxt;
    olast_r  <= olast_nxt;
    otrunc_r <= otrunc_nxt;
  end

  assign out_point.valid       = ov_r;
  assign out_point.point_x     = ox_r;
  assign out_point.point_y     = oy_r;
  assign out_point.point_z     = oz_r;
  assign out_point.last_of_run = olast_r;
  assign out_point.truncated   = otrunc_r;

`ifndef SYNTHESIS
  // one vertex in flight at a time
  a_one_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    in_vertex.valid && in_vertex.ready |=> !in_vertex.ready)
    else $error("vertex taken while another is in flight");

  // a new vertex never finds a point still held back
  a_no_held_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_vertex.ready |-> !held_v_r)
    else $error("held point left over at idle");

  // serial unit is only started when free
  a_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ar_cmd.start |-> !ar_stat.busy)
    else $error("serial unit started while busy");

  // points per segment stay within budget
  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_EMIT))
    else $error("segment point count beyond budget");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/plr_arith.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plr_arith
// bit-serial multiply-accumulate, restoring divide and integer square root
// ----------------------------------------------------------------------------
module plr_arith
  import plr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire plr_cmd_t        cmd,
  input  wire logic [DW-1:0]   opa,
  input  wire logic [DW-1:0]   opb,
  input  wire logic [ACC_W-1:0] init,
  output plr_stat_t            stat,
  output logic [ACC_W-1:0]     acc
);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] mc_r, mc_nxt;
  logic [DW-1:0]    mp_r, mp_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [34:0]      rem_r, rem_nxt;
  logic [DW-1:0]    root_r, root_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DW:0]      dtry;
  logic [36:0]      r2, trial;
  logic             sq_ge;
  logic [DW-1:0]    root_new;

  always_comb begin
    dtry     = {rem_r[DW-1:0], acc_r[ACC_W-1]};
    r2       = {rem_r, acc_r[ACC_W-1:ACC_W-2]};
    trial    = {2'b00, root_r, 2'b01};
    sq_ge    = r2 >= trial;
    root_new = {root_r[DW-2:0], sq_ge};

    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (cmd.start) begin
      op_nxt   = cmd.op;
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      root_nxt = '0;
      unique case (cmd.op)
        OP_MAC: begin
          acc_nxt = cmd.load ? init : acc_r;
          mc_nxt  = ACC_W'(opa);
          mp_nxt  = opb;
          cnt_nxt = 7'(DW);
        end
        OP_DIV: begin
          den_nxt = opb;
          cnt_nxt = 7'(ACC_W);
        end
        OP_SQRT: begin
          cnt_nxt = 7'(DW);
        end
        default: begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      unique case (op_r)
        OP_MAC: begin
          if (mp_r[0]) acc_nxt = acc_r + mc_r;
          mc_nxt = {mc_r[ACC_W-2:0], 1'b0};
          mp_nxt = {1'b0, mp_r[DW-1:1]};
        end
        OP_DIV: begin
          if (dtry >= {1'b0, den_r}) begin
            rem_nxt = 35'(DW'(dtry - {1'b0, den_r}));
            acc_nxt = {acc_r[ACC_W-2:0], 1'b1};
          end else begin
            rem_nxt = 35'(dtry[DW-1:0]);
            acc_nxt = {acc_r[ACC_W-2:0], 1'b0};
          end
        end
        OP_SQRT: begin
          rem_nxt  = sq_ge ? 35'(r2 - trial) : r2[34:0];
          root_nxt = root_new;
          acc_nxt  = {acc_r[ACC_W-3:0], 2'b00};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (op_r == OP_SQRT) acc_nxt = ACC_W'(root_new);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MAC;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    acc_r  <= acc_nxt;
    mc_r   <= mc_nxt;
    mp_r   <= mp_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign acc       = acc_r;

endmodule
`default_nettype wire
